// File: rtl/core/piwb_pkg.sv
`default_nettype none
package piwb_pkg;

	// Quotient bits of the acceleration divide: (|force| << 16) / density.
	localparam int DIV_BITS = 48;
	localparam int AXES     = 3;

	// Register reset values.
	localparam logic [31:0] TIME_STEP_RST   = 32'd1717987;
	localparam logic [16:0] RESTITUTION_RST = 17'd52429;
	localparam logic [24:0] WALL_LOW_RST    = 25'd65536;
	localparam logic [24:0] WALL_HIGH_RST   = 25'd16777216;

	typedef enum logic [1:0] {
		REG_TIME_STEP   = 2'd0,
		REG_RESTITUTION = 2'd1,
		REG_WALL_LOW    = 2'd2,
		REG_WALL_HIGH   = 2'd3
	} piwb_reg_t;

	typedef struct packed {
		logic        [24:0] pos_x;
		logic        [24:0] pos_y;
		logic        [24:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic signed [31:0] net_force_x;
		logic signed [31:0] net_force_y;
		logic signed [31:0] net_force_z;
		logic        [31:0] density;
	} piwb_in_t;

	typedef struct packed {
		logic        [24:0] new_pos_x;
		logic        [24:0] new_pos_y;
		logic        [24:0] new_pos_z;
		logic signed [31:0] new_vel_x;
		logic signed [31:0] new_vel_y;
		logic signed [31:0] new_vel_z;
		logic        [2:0]  wall_hit_mask;
		logic               density_zero;
	} piwb_out_t;

	// Fields that ride alongside the divider.
	typedef struct packed {
		logic [AXES-1:0][24:0] pos;
		logic [AXES-1:0][31:0] vel;
		logic [AXES-1:0]       neg;
		logic                  dz;
	} piwb_side_t;

	// One restoring divide step: shift in a dividend bit, subtract if it fits.
	function automatic logic [32:0] div_step(input logic [31:0] rem, input logic nbit,
			input logic [31:0] den);
		logic [32:0] t;
		logic [32:0] d;
		t = {rem, nbit};
		d = {1'b0, den};
		if (t >= d) begin
			t = t - d;
			return {t[31:0], 1'b1};
		end
		return {t[31:0], 1'b0};
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/piwb_div.sv
`default_nettype none
module piwb_div (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      in_valid,
	input  wire logic [piwb_pkg::AXES-1:0][47:0]           num,
	input  wire logic [31:0]                               den,
	input  wire piwb_pkg::piwb_side_t                      side_in,
	output logic                                           out_valid,
	output logic [piwb_pkg::AXES-1:0][47:0]                quo,
	output piwb_pkg::piwb_side_t                           side_out
);
	import piwb_pkg::*;

	// One quotient bit per stage; the dividend shifts out as quotient bits shift in.
	logic                       vld_s  [DIV_BITS];
	logic [AXES-1:0][47:0]      nq_s   [DIV_BITS];
	logic [AXES-1:0][31:0]      rem_s  [DIV_BITS];
	logic [31:0]                den_s  [DIV_BITS];
	piwb_side_t                 side_s [DIV_BITS];

	for (genvar k = 0; k < DIV_BITS; k++) begin : g_st
		logic                  v_in;
		logic [AXES-1:0][47:0] n_in;
		logic [AXES-1:0][31:0] r_in;
		logic [31:0]           d_in;
		piwb_side_t            sd_in;
		logic [AXES-1:0][47:0] n_nx;
		logic [AXES-1:0][31:0] r_nx;

		if (k == 0) begin : g_first
			assign v_in  = in_valid;
			assign n_in  = num;
			assign r_in  = '0;
			assign d_in  = den;
			assign sd_in = side_in;
		end else begin : g_next
			assign v_in  = vld_s[k-1];
			assign n_in  = nq_s[k-1];
			assign r_in  = rem_s[k-1];
			assign d_in  = den_s[k-1];
			assign sd_in = side_s[k-1];
		end

		always_comb begin
			logic [32:0] st;
			for (int a = 0; a < AXES; a++) begin
				st      = div_step(r_in[a], n_in[a][47], d_in);
				r_nx[a] = st[32:1];
				n_nx[a] = {n_in[a][46:0], st[0]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			nq_s[k]   <= n_nx;
			rem_s[k]  <= r_nx;
			den_s[k]  <= d_in;
			side_s[k] <= sd_in;
		end
	end

	assign out_valid = vld_s[DIV_BITS-1];
	assign quo       = nq_s[DIV_BITS-1];
	assign side_out  = side_s[DIV_BITS-1];

endmodule
`default_nettype wire

// File: rtl/core/piwb_mulshr.sv
`default_nettype none
module piwb_mulshr (
	input  wire logic        clk,
	input  wire logic [47:0] m,
	input  wire logic [31:0] d,
	output logic      [47:0] res
);
	import piwb_pkg::*;

	logic [55:0] ph_s1;
	logic [55:0] pl_s1;
	logic [79:0] sum;

	// Two 24x32 partial products, then floor(m*d / 2^32).
	always_ff @(posedge clk) begin
		ph_s1 <= 56'(m[47:24] * d);
		pl_s1 <= 56'(m[23:0] * d);
	end

	assign sum = {ph_s1, 24'b0} + {24'b0, pl_s1};

	always_ff @(posedge clk) begin
		res <= sum[79:32];
	end

endmodule
`default_nettype wire

// File: rtl/core/particle_integrate_wall_bounce.sv
// Channel   Handshake          Payload     Direction
// item      start / busy       piwb_in_t   in
// result    done (strobe)      piwb_out_t  out
// config    cfg_we             cfg_idx, cfg_wdata  in
//
// One particle is accepted per cycle; busy is never raised.
// The pipeline holds 48 divider stages, 2 per multiply (two of them),
// and the velocity add, position add, wall test and output stages.
// Reset clears the valid chain and loads the register defaults.
// The receiver cannot stall, so the pipeline always advances.
`default_nettype none
module particle_integrate_wall_bounce (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire piwb_pkg::piwb_in_t   item,
	output logic                      done,
	output piwb_pkg::piwb_out_t       result,
	input  wire logic                 cfg_we,
	input  wire logic [1:0]           cfg_idx,
	input  wire logic [31:0]          cfg_wdata
);
	import piwb_pkg::*;

	logic [31:0] time_step_q;
	logic [16:0] restitution_q;
	logic [24:0] wall_low_q;
	logic [24:0] wall_high_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q   <= TIME_STEP_RST;
			restitution_q <= RESTITUTION_RST;
			wall_low_q    <= WALL_LOW_RST;
			wall_high_q   <= WALL_HIGH_RST;
		end else if (cfg_we) begin
			unique case (piwb_reg_t'(cfg_idx))
				REG_TIME_STEP:   time_step_q   <= cfg_wdata;
				REG_RESTITUTION: restitution_q <= cfg_wdata[16:0];
				REG_WALL_LOW:    wall_low_q    <= cfg_wdata[24:0];
				REG_WALL_HIGH:   wall_high_q   <= cfg_wdata[24:0];
			endcase
		end
	end

	assign busy = 1'b0;

	// Force magnitudes, signs and the side fields of an accepted beat.
	logic                  in_vld;
	logic [AXES-1:0][31:0] frc;
	logic [AXES-1:0][47:0] num;
	piwb_side_t            side_in;

	assign in_vld = start & ~busy;
	assign frc    = {item.net_force_z, item.net_force_y, item.net_force_x};

	always_comb begin
		logic [31:0] mag;
		side_in.pos = {item.pos_z, item.pos_y, item.pos_x};
		side_in.vel = {item.vel_z, item.vel_y, item.vel_x};
		side_in.dz  = (item.density == '0);
		for (int a = 0; a < AXES; a++) begin
			mag             = frc[a][31] ? 32'(-frc[a]) : frc[a];
			side_in.neg[a]  = frc[a][31];
			num[a]          = {mag, 16'b0};
		end
	end

	logic                  div_vld;
	logic [AXES-1:0][47:0] quo;
	piwb_side_t            div_side;

	piwb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_vld),
		.num      (num),
		.den      (item.density),
		.side_in  (side_in),
		.out_valid(div_vld),
		.quo      (quo),
		.side_out (div_side)
	);

	// dv = acc * dt / 2^33, taken as the /2^32 product halved.
	logic [AXES-1:0][47:0] acc_mag;
	logic [AXES-1:0][47:0] dv_raw;

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			acc_mag[a] = div_side.dz ? 48'd0 : quo[a];
		end
	end

	logic       vld_s1, vld_s2;
	piwb_side_t side_s1, side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= div_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= div_side;
		side_s2 <= side_s1;
	end

	// Velocity add, kept wide and unsaturated.
	logic                         vld_s3;
	logic [AXES-1:0][24:0]        pos_s3;
	logic [AXES-1:0][48:0]        vf_s3;
	logic                         dz_s3;
	logic [AXES-1:0][48:0]        vf_nx;
	logic [AXES-1:0][47:0]        vf_mag;

	always_comb begin
		logic [48:0] dv;
		logic [48:0] vx;
		for (int a = 0; a < AXES; a++) begin
			dv       = {2'b0, dv_raw[a][47:1]};
			vx       = {{17{side_s2.vel[a][31]}}, side_s2.vel[a]};
			vf_nx[a] = side_s2.neg[a] ? vx - dv : vx + dv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		pos_s3 <= side_s2.pos;
		vf_s3  <= vf_nx;
		dz_s3  <= side_s2.dz;
	end

	always_comb begin
		logic [48:0] t;
		for (int a = 0; a < AXES; a++) begin
			t         = vf_s3[a][48] ? 49'(-vf_s3[a]) : vf_s3[a];
			vf_mag[a] = t[47:0];
		end
	end

	logic [AXES-1:0][47:0] dp_raw;

	for (genvar a = 0; a < AXES; a++) begin : g_mul
		piwb_mulshr u_mul_dv (
			.clk(clk),
			.m  (acc_mag[a]),
			.d  (time_step_q),
			.res(dv_raw[a])
		);
		piwb_mulshr u_mul_dp (
			.clk(clk),
			.m  (vf_mag[a]),
			.d  (time_step_q),
			.res(dp_raw[a])
		);
	end

	logic                  vld_s4, vld_s5;
	logic [AXES-1:0][24:0] pos_s4, pos_s5;
	logic [AXES-1:0][48:0] vf_s4, vf_s5;
	logic                  dz_s4, dz_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		pos_s4 <= pos_s3;
		pos_s5 <= pos_s4;
		vf_s4  <= vf_s3;
		vf_s5  <= vf_s4;
		dz_s4  <= dz_s3;
		dz_s5  <= dz_s4;
	end

	// Position add and velocity saturation.
	logic                  vld_s6;
	logic [AXES-1:0][49:0] p_s6;
	logic [AXES-1:0][31:0] v_s6;
	logic                  dz_s6;
	logic [AXES-1:0][49:0] p_nx;
	logic [AXES-1:0][31:0] v_nx;

	always_comb begin
		logic [49:0] pz;
		logic [49:0] dz50;
		for (int a = 0; a < AXES; a++) begin
			pz      = {25'b0, pos_s5[a]};
			dz50    = {2'b0, dp_raw[a]};
			p_nx[a] = vf_s5[a][48] ? pz - dz50 : pz + dz50;
			if ($signed(vf_s5[a]) > 49'sd2147483647) begin
				v_nx[a] = 32'h7fffffff;
			end else if ($signed(vf_s5[a]) < -49'sd2147483648) begin
				v_nx[a] = 32'h80000000;
			end else begin
				v_nx[a] = vf_s5[a][31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		p_s6  <= p_nx;
		v_s6  <= v_nx;
		dz_s6 <= dz_s5;
	end

	// Wall test, clamp and the restitution product; the low wall wins.
	logic                  vld_s7;
	logic [AXES-1:0][24:0] pc_s7;
	logic [AXES-1:0]       hit_s7;
	logic [AXES-1:0]       vneg_s7;
	logic [AXES-1:0][48:0] prod_s7;
	logic [AXES-1:0][31:0] v_s7;
	logic                  dz_s7;
	logic [AXES-1:0][24:0] pc_nx;
	logic [AXES-1:0]       hit_nx;
	logic [AXES-1:0][48:0] prod_nx;

	always_comb begin
		logic lo;
		logic hi;
		logic [31:0] vm;
		for (int a = 0; a < AXES; a++) begin
			lo = $signed(p_s6[a]) < $signed({25'b0, wall_low_q});
			hi = $signed(p_s6[a]) > $signed({25'b0, wall_high_q});
			hit_nx[a] = lo | hi;
			if (lo) begin
				pc_nx[a] = wall_low_q;
			end else if (hi) begin
				pc_nx[a] = wall_high_q;
			end else begin
				pc_nx[a] = p_s6[a][24:0];
			end
			vm         = v_s6[a][31] ? 32'(-v_s6[a]) : v_s6[a];
			prod_nx[a] = 49'(vm * restitution_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		pc_s7   <= pc_nx;
		hit_s7  <= hit_nx;
		prod_s7 <= prod_nx;
		for (int a = 0; a < AXES; a++) begin
			vneg_s7[a] <= v_s6[a][31];
		end
		v_s7    <= v_s6;
		dz_s7   <= dz_s6;
	end

	// Reflected velocity with opposite sign, saturated, on a wall hit; otherwise passed through.
	logic [AXES-1:0][31:0] vo;

	always_comb begin
		logic [32:0] m;
		for (int a = 0; a < AXES; a++) begin
			m = prod_s7[a][48:16];
			if (!hit_s7[a]) begin
				vo[a] = v_s7[a];
			end else if (vneg_s7[a]) begin
				vo[a] = (m > 33'h07fffffff) ? 32'h7fffffff : m[31:0];
			end else begin
				vo[a] = (m > 33'h080000000) ? 32'h80000000 : 32'(-m[31:0]);
			end
		end
	end

	// Output register and strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		result.new_pos_x     <= pc_s7[0];
		result.new_pos_y     <= pc_s7[1];
		result.new_pos_z     <= pc_s7[2];
		result.new_vel_x     <= vo[0];
		result.new_vel_y     <= vo[1];
		result.new_vel_z     <= vo[2];
		result.wall_hit_mask <= hit_s7;
		result.density_zero  <= dz_s7;
	end

`ifndef SYNTH
	// A result position never lies above both walls on any axis.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((result.new_pos_x <= wall_low_q) || (result.new_pos_x <= wall_high_q))
			&& ((result.new_pos_y <= wall_low_q) || (result.new_pos_y <= wall_high_q))
			&& ((result.new_pos_z <= wall_low_q) || (result.new_pos_z <= wall_high_q)))
		else $error("result position beyond both walls");

	// Every beat past the velocity add reaches the output through vld_s4 to vld_s7 and the done register.
	a_tail_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(vld_s3, 5))
		else $error("beat lost or invented in the pipeline tail");

	// A beat leaving the divider shows up at the velocity add through vld_s1, vld_s2 and vld_s3.
	a_mid_latency: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 == $past(div_vld, 3))
		else $error("beat lost between divider and velocity add");
`endif

endmodule
`default_nettype wire
